// ----- rtl/core/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and layout/rule tables for the Hangul composer.
// ----------------------------------------------------------------------------
package hsc_pkg;

    // Default depth of the internal request queues
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [15:0] SYL_BASE     = 16'hAC00;
    localparam logic [15:0] JAMO_BASE    = 16'h1100;
    localparam logic [15:0] SYL_PER_INIT = 16'd588;   // 21 medials * 28 finals
    localparam logic [15:0] SYL_PER_MED  = 16'd28;
    localparam logic [4:0]  SILENT_INIT  = 5'd11;     // ieung

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_LATIN = 2'd1,
        KIND_LONE  = 2'd2,
        KIND_SYL   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_CONS  = 2'd1,
        PH_VOWEL = 2'd2,
        PH_FINAL = 2'd3
    } phase_t;

    // Table hit with index
    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } lookup_t;

    // Classified key request, front to back
    typedef struct packed {
        logic       clear;
        logic       is_cons;
        logic       is_vowel;
        logic [4:0] jamo;
        logic [7:0] key;
    } cls_t;

    // Result request, back to output
    typedef struct packed {
        kind_t       kind;
        logic [15:0] code_point;
        logic [23:0] utf8_bytes;
        logic        commit_valid;
        logic [15:0] commit_code;
    } res_t;

    // Consonant key -> initial index
    function automatic lookup_t cons_lookup(input logic [7:0] key);
        lookup_t r;
        r.hit = 1'b1;
        case (key)
            "r":     r.idx = 5'd0;
            "R":     r.idx = 5'd1;
            "s":     r.idx = 5'd2;
            "e":     r.idx = 5'd3;
            "E":     r.idx = 5'd4;
            "f":     r.idx = 5'd5;
            "a":     r.idx = 5'd6;
            "q":     r.idx = 5'd7;
            "Q":     r.idx = 5'd8;
            "t":     r.idx = 5'd9;
            "T":     r.idx = 5'd10;
            "d":     r.idx = 5'd11;
            "w":     r.idx = 5'd12;
            "W":     r.idx = 5'd13;
            "c":     r.idx = 5'd14;
            "z":     r.idx = 5'd15;
            "x":     r.idx = 5'd16;
            "v":     r.idx = 5'd17;
            "g":     r.idx = 5'd18;
            default: begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    // Vowel key -> medial index
    function automatic lookup_t vowel_lookup(input logic [7:0] key);
        lookup_t r;
        r.hit = 1'b1;
        case (key)
            "y":     r.idx = 5'd12;
            "u":     r.idx = 5'd6;
            "i":     r.idx = 5'd2;
            "o":     r.idx = 5'd1;
            "p":     r.idx = 5'd5;
            "h":     r.idx = 5'd8;
            "j":     r.idx = 5'd4;
            "k":     r.idx = 5'd0;
            "l":     r.idx = 5'd20;
            "b":     r.idx = 5'd17;
            "n":     r.idx = 5'd13;
            "m":     r.idx = 5'd18;
            default: begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    // Initial index -> single final index; miss for double tigeut/bieup/jieut
    function automatic lookup_t init_to_final(input logic [4:0] ini);
        lookup_t r;
        r.hit = 1'b1;
        case (ini)
            5'd0:    r.idx = 5'd0;
            5'd1:    r.idx = 5'd1;
            5'd2:    r.idx = 5'd3;
            5'd3:    r.idx = 5'd6;
            5'd5:    r.idx = 5'd7;
            5'd6:    r.idx = 5'd15;
            5'd7:    r.idx = 5'd16;
            5'd9:    r.idx = 5'd18;
            5'd10:   r.idx = 5'd19;
            5'd11:   r.idx = 5'd20;
            5'd12:   r.idx = 5'd21;
            5'd14:   r.idx = 5'd22;
            5'd15:   r.idx = 5'd23;
            5'd16:   r.idx = 5'd24;
            5'd17:   r.idx = 5'd25;
            5'd18:   r.idx = 5'd26;
            default: begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    // Diphthong rules: base medial + added medial
    function automatic lookup_t diph_lookup(input logic [4:0] base, input logic [4:0] add);
        lookup_t r;
        r.hit = 1'b1;
        case ({base, add})
            {5'd8,  5'd0}:  r.idx = 5'd9;
            {5'd8,  5'd1}:  r.idx = 5'd10;
            {5'd8,  5'd20}: r.idx = 5'd11;
            {5'd13, 5'd4}:  r.idx = 5'd14;
            {5'd13, 5'd5}:  r.idx = 5'd15;
            {5'd13, 5'd20}: r.idx = 5'd16;
            {5'd18, 5'd20}: r.idx = 5'd19;
            default: begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    // Complex final rules: base final + added final
    function automatic lookup_t comb_lookup(input logic [4:0] base, input logic [4:0] add);
        lookup_t r;
        r.hit = 1'b1;
        case ({base, add})
            {5'd0,  5'd18}: r.idx = 5'd2;
            {5'd3,  5'd21}: r.idx = 5'd4;
            {5'd3,  5'd26}: r.idx = 5'd5;
            {5'd7,  5'd0}:  r.idx = 5'd8;
            {5'd7,  5'd15}: r.idx = 5'd9;
            {5'd7,  5'd16}: r.idx = 5'd10;
            {5'd7,  5'd18}: r.idx = 5'd11;
            {5'd7,  5'd24}: r.idx = 5'd12;
            {5'd7,  5'd25}: r.idx = 5'd13;
            {5'd7,  5'd26}: r.idx = 5'd14;
            {5'd16, 5'd18}: r.idx = 5'd17;
            default: begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    // Final (plus one) left behind when a vowel follows
    function automatic logic [4:0] split_keep(input logic [4:0] fin);
        logic [4:0] r;
        case (fin)
            5'd2:    r = 5'd1;
            5'd4:    r = 5'd4;
            5'd5:    r = 5'd4;
            5'd8,
            5'd9,
            5'd10,
            5'd11,
            5'd12,
            5'd13,
            5'd14:   r = 5'd8;
            5'd17:   r = 5'd17;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Initial carried into the next syllable when a vowel follows
    function automatic logic [4:0] split_move(input logic [4:0] fin);
        logic [4:0] r;
        case (fin)
            5'd0:    r = 5'd0;
            5'd1:    r = 5'd1;
            5'd2:    r = 5'd9;
            5'd3:    r = 5'd2;
            5'd4:    r = 5'd12;
            5'd5:    r = 5'd18;
            5'd6:    r = 5'd3;
            5'd7:    r = 5'd5;
            5'd8:    r = 5'd0;
            5'd9:    r = 5'd6;
            5'd10:   r = 5'd7;
            5'd11:   r = 5'd9;
            5'd12:   r = 5'd16;
            5'd13:   r = 5'd17;
            5'd14:   r = 5'd18;
            5'd15:   r = 5'd6;
            5'd16:   r = 5'd7;
            5'd17:   r = 5'd9;
            5'd18:   r = 5'd9;
            5'd19:   r = 5'd10;
            5'd20:   r = 5'd11;
            5'd21:   r = 5'd12;
            5'd22:   r = 5'd14;
            5'd23:   r = 5'd15;
            5'd24:   r = 5'd16;
            5'd25:   r = 5'd17;
            5'd26:   r = 5'd18;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Three-byte UTF-8 encoding, first byte highest
    function automatic logic [23:0] utf8_of(input logic [15:0] cp);
        return {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
    endfunction

endpackage

// ----- rtl/core/hsc_queue.sv -----
// ----------------------------------------------------------------------------
// hsc_queue
// Small register FIFO used between the front, back and output sides.
// ----------------------------------------------------------------------------
module hsc_queue #(
    parameter type         T     = logic [7:0],
    parameter int unsigned DEPTH = hsc_pkg::QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     din,
    output logic full,
    input  logic pop,
    output T     dout,
    output logic empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    T               mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, payload only
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/core/hsc_front.sv -----
// ----------------------------------------------------------------------------
// hsc_front
// Accepts key requests and classifies them as clear, consonant, vowel or Latin.
// ----------------------------------------------------------------------------
module hsc_front (
    input  logic          command,
    input  logic [7:0]    key_code,
    input  logic          push,
    output logic          full,
    output logic          q_push,
    output hsc_pkg::cls_t q_item,
    input  logic          q_full
);
    import hsc_pkg::*;

    lookup_t cons_hit;
    lookup_t vowel_hit;

    assign cons_hit  = cons_lookup(key_code);
    assign vowel_hit = vowel_lookup(key_code);

    // Classify; consonant table has priority, clear overrides the key
    always_comb
    begin
        q_item.clear    = command;
        q_item.is_cons  = !command && cons_hit.hit;
        q_item.is_vowel = !command && !cons_hit.hit && vowel_hit.hit;
        q_item.jamo     = cons_hit.hit ? cons_hit.idx : vowel_hit.idx;
        q_item.key      = key_code;
    end

    assign q_push = push;
    assign full   = q_full;

endmodule

// ----- rtl/core/hsc_back.sv -----
// ----------------------------------------------------------------------------
// hsc_back
// Composition automaton: applies the syllable rules and builds the result.
// ----------------------------------------------------------------------------
module hsc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cls_empty,
    input  hsc_pkg::cls_t cls_item,
    output logic          cls_pop,
    input  logic          res_full,
    output logic          res_push,
    output hsc_pkg::res_t res_item
);
    import hsc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  ini_reg, ini_next;
    logic [4:0]  med_reg, med_next;
    logic [4:0]  fpo_reg, fpo_next;
    logic [15:0] code_reg, code_next;

    logic        go;
    lookup_t     itf;
    lookup_t     cmb;
    lookup_t     dph;
    logic [4:0]  fin_idx;
    logic [4:0]  keep;
    logic [15:0] syl_code;

    assign go       = !cls_empty && !res_full;
    assign cls_pop  = go;
    assign res_push = go;

    assign fin_idx = fpo_reg - 1'b1;
    assign itf     = init_to_final(cls_item.jamo);
    assign cmb     = comb_lookup(fin_idx, itf.idx);
    assign dph     = diph_lookup(med_reg, cls_item.jamo);
    assign keep    = split_keep(fin_idx);

    // Next state and result
    always_comb
    begin
        phase_next            = phase_reg;
        ini_next              = ini_reg;
        med_next              = med_reg;
        fpo_next              = fpo_reg;
        res_item.commit_valid = 1'b0;
        res_item.commit_code  = '0;

        if (cls_item.clear)
        begin
            phase_next = PH_NONE;
            ini_next   = '0;
            med_next   = '0;
            fpo_next   = '0;
        end
        else if (cls_item.is_cons)
        begin
            case (phase_reg)
                PH_NONE:
                begin
                    phase_next = PH_CONS;
                    ini_next   = cls_item.jamo;
                    med_next   = '0;
                    fpo_next   = '0;
                end
                PH_VOWEL:
                begin
                    if (itf.hit)
                    begin
                        fpo_next   = itf.idx + 1'b1;
                        phase_next = PH_FINAL;
                    end
                    else
                    begin
                        res_item.commit_valid = 1'b1;
                        res_item.commit_code  = code_reg;
                        phase_next = PH_CONS;
                        ini_next   = cls_item.jamo;
                        med_next   = '0;
                        fpo_next   = '0;
                    end
                end
                PH_FINAL:
                begin
                    if (itf.hit && cmb.hit)
                    begin
                        fpo_next = cmb.idx + 1'b1;
                    end
                    else
                    begin
                        res_item.commit_valid = 1'b1;
                        res_item.commit_code  = code_reg;
                        phase_next = PH_CONS;
                        ini_next   = cls_item.jamo;
                        med_next   = '0;
                        fpo_next   = '0;
                    end
                end
                default:
                begin
                    // lone consonant followed by a consonant
                    res_item.commit_valid = 1'b1;
                    res_item.commit_code  = code_reg;
                    phase_next = PH_CONS;
                    ini_next   = cls_item.jamo;
                    med_next   = '0;
                    fpo_next   = '0;
                end
            endcase
        end
        else if (cls_item.is_vowel)
        begin
            case (phase_reg)
                PH_NONE:
                begin
                    phase_next = PH_VOWEL;
                    ini_next   = SILENT_INIT;
                    med_next   = cls_item.jamo;
                    fpo_next   = '0;
                end
                PH_CONS:
                begin
                    phase_next = PH_VOWEL;
                    med_next   = cls_item.jamo;
                end
                PH_VOWEL:
                begin
                    if (dph.hit)
                    begin
                        med_next = dph.idx;
                    end
                    else
                    begin
                        res_item.commit_valid = 1'b1;
                        res_item.commit_code  = code_reg;
                        phase_next = PH_VOWEL;
                        ini_next   = SILENT_INIT;
                        med_next   = cls_item.jamo;
                        fpo_next   = '0;
                    end
                end
                default:
                begin
                    // final splits or moves into the next syllable
                    res_item.commit_valid = 1'b1;
                    res_item.commit_code  = code_reg - {11'd0, fpo_reg} + {11'd0, keep};
                    phase_next = PH_VOWEL;
                    ini_next   = split_move(fin_idx);
                    med_next   = cls_item.jamo;
                    fpo_next   = '0;
                end
            endcase
        end

        // Preedit code of the new state
        syl_code = SYL_BASE + {11'd0, ini_next} * SYL_PER_INIT
                 + {11'd0, med_next} * SYL_PER_MED + {11'd0, fpo_next};
        case (phase_next)
            PH_CONS:  code_next = JAMO_BASE + {11'd0, ini_next};
            PH_VOWEL,
            PH_FINAL: code_next = syl_code;
            default:  code_next = '0;
        endcase

        // Result fields
        if (cls_item.clear)
        begin
            res_item.kind       = KIND_EMPTY;
            res_item.code_point = '0;
            res_item.utf8_bytes = '0;
        end
        else if (!cls_item.is_cons && !cls_item.is_vowel)
        begin
            res_item.kind       = KIND_LATIN;
            res_item.code_point = {8'd0, cls_item.key};
            res_item.utf8_bytes = '0;
        end
        else
        begin
            res_item.kind       = (phase_next == PH_CONS) ? KIND_LONE : KIND_SYL;
            res_item.code_point = code_next;
            res_item.utf8_bytes = utf8_of(code_next);
        end
    end

    // Composition state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NONE;
            ini_reg   <= '0;
            med_reg   <= '0;
            fpo_reg   <= '0;
            code_reg  <= '0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            ini_reg   <= ini_next;
            med_reg   <= med_next;
            fpo_reg   <= fpo_next;
            code_reg  <= code_next;
        end
    end

endmodule

// ----- rtl/core/hangul_syllable_composer_core.sv -----
// Keys pass the request queue and the automaton into the result queue driving the outputs.
// One key per cycle while the result queue has room; composer state updates once per key.
// Queue depth sets how far either side may stall without stalling the other.
// Reset: asynchronous, clears both queues and returns composition to no syllable.
// ----------------------------------------------------------------------------
// hangul_syllable_composer_core
// Two-set Hangul composer: classifier, request queue, automaton, result queue.
// ----------------------------------------------------------------------------
module hangul_syllable_composer_core #(
    parameter int unsigned QUEUE_DEPTH = hsc_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [7:0]  key_code,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [15:0] code_point,
    output logic [23:0] utf8_bytes,
    output logic        commit_valid,
    output logic [15:0] commit_code
);
    import hsc_pkg::*;

    logic  cls_push, cls_full, cls_empty, cls_pop;
    cls_t  cls_in, cls_head;
    logic  res_push, res_full;
    res_t  res_in, res_head;

    // Front: accept and classify keys
    hsc_front u_front (
        .command  (command),
        .key_code (key_code),
        .push     (push),
        .full     (full),
        .q_push   (cls_push),
        .q_item   (cls_in),
        .q_full   (cls_full)
    );

    // Classified request queue
    hsc_queue #(
        .T     (cls_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cls_push),
        .din   (cls_in),
        .full  (cls_full),
        .pop   (cls_pop),
        .dout  (cls_head),
        .empty (cls_empty)
    );

    // Back: composition automaton
    hsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_empty (cls_empty),
        .cls_item  (cls_head),
        .cls_pop   (cls_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (res_in)
    );

    // Result queue
    hsc_queue #(
        .T     (res_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty)
    );

    assign kind         = res_head.kind;
    assign code_point   = res_head.code_point;
    assign utf8_bytes   = res_head.utf8_bytes;
    assign commit_valid = res_head.commit_valid;
    assign commit_code  = res_head.commit_code;

    // Checks
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !empty)
        else $error("processed request did not reach result queue");

    a_no_stray_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !commit_valid) |-> (commit_code == 16'd0))
        else $error("commit code without commit");

    a_latin_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_LATIN) |-> (utf8_bytes == 24'd0 && !commit_valid))
        else $error("Latin passthrough carries encoding or commit");

    a_lone_jamo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_LONE) |-> (code_point[15:8] == 8'h11))
        else $error("lone jamo outside choseong block");

endmodule
